// ===== rtl/core/tre_pkg.sv =====
// ----------------------------------------------------------------------------
// tre_pkg
// Types and codes shared by the IO trigger rule engine and its sub-blocks.
// ----------------------------------------------------------------------------
package tre_pkg;

    // Item operation codes
    localparam logic [1:0] OP_SAMPLE = 2'd0;
    localparam logic [1:0] OP_TICK   = 2'd1;
    localparam logic [1:0] OP_APPEND = 2'd2;
    localparam logic [1:0] OP_CLEAR  = 2'd3;

    // Configuration register indexes
    localparam logic CFG_PORT_B_MASK = 1'b0;
    localparam logic CFG_PORT_D_MASK = 1'b1;

    localparam int CFG_DATA_W = 8;

    // Flag bit positions in the mode nibble
    localparam int FLAG_EDGE  = 0;
    localparam int FLAG_RISE  = 1;
    localparam int FLAG_CLEAR = 2;
    localparam int FLAG_SET   = 3;

    localparam logic [7:0] MASK_RESET = 8'hFF;

    // Static part of a trigger, written once at append
    typedef struct packed {
        logic [7:0] out_b;
        logic [7:0] out_d;
        logic [7:0] out_s;
        logic [7:0] in_b;
        logic [7:0] in_d;
        logic [7:0] in_s;
        logic [3:0] flags;
        logic [7:0] reload;
    } tre_entry_t;

    // Timer part of a trigger, updated by samples and ticks
    typedef struct packed {
        logic [7:0] count;
        logic       expired;
    } tre_dyn_t;

    // Output latches and status byte
    typedef struct packed {
        logic [7:0] latch_b;
        logic [7:0] latch_d;
        logic [7:0] status;
    } tre_io_t;

    // Snapshot of one sample and its changes against the previous one
    typedef struct packed {
        logic [7:0] cb;
        logic [7:0] cd;
        logic [7:0] cs;
        logic [7:0] chb;
        logic [7:0] chd;
        logic [7:0] chs;
    } tre_snap_t;

endpackage

// ===== rtl/core/tre_if.sv =====
// ----------------------------------------------------------------------------
// tre_if
// Valid/ready channels for input items and results of the trigger engine.
// ----------------------------------------------------------------------------
interface tre_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] op;
    logic [7:0] pin_b;
    logic [7:0] pin_d;
    logic [7:0] status_set;
    logic [7:0] status_clear;
    logic [7:0] new_out_b;
    logic [7:0] new_out_d;
    logic [7:0] new_out_status;
    logic [7:0] new_in_b;
    logic [7:0] new_in_d;
    logic [7:0] new_in_status;
    logic [7:0] new_mode_time;

    modport source (
        output valid, op, pin_b, pin_d, status_set, status_clear,
               new_out_b, new_out_d, new_out_status,
               new_in_b, new_in_d, new_in_status, new_mode_time,
        input  ready
    );
    modport sink (
        input  valid, op, pin_b, pin_d, status_set, status_clear,
               new_out_b, new_out_d, new_out_status,
               new_in_b, new_in_d, new_in_status, new_mode_time,
        output ready
    );
endinterface

interface tre_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] port_b_drive;
    logic [7:0] port_d_drive;
    logic [7:0] status_now;
    logic       accepted;

    modport source (
        output valid, port_b_drive, port_d_drive, status_now, accepted,
        input  ready
    );
    modport sink (
        input  valid, port_b_drive, port_d_drive, status_now, accepted,
        output ready
    );
endinterface

// ===== rtl/core/tre_table.sv =====
// ----------------------------------------------------------------------------
// tre_table
// Trigger table storage: static fields and timer state, one entry read per
// cycle through a registered read port.
// ----------------------------------------------------------------------------
module tre_table
    import tre_pkg::*;
#(
    parameter int MAX_TRIGGERS = 8,
    parameter int IDX_W        = 3
)
(
    input  logic             clk,
    input  logic             app_we,
    input  logic [IDX_W-1:0] app_idx,
    input  tre_entry_t       app_entry,
    input  logic             dyn_we,
    input  logic [IDX_W-1:0] dyn_idx,
    input  tre_dyn_t         dyn_wdata,
    input  logic [IDX_W-1:0] rd_idx,
    output tre_entry_t       rd_entry,
    output tre_dyn_t         rd_dyn
);

    tre_entry_t entry_mem [MAX_TRIGGERS];
    tre_dyn_t   dyn_mem   [MAX_TRIGGERS];

    always_ff @(posedge clk)
    begin
        if (app_we)
        begin
            entry_mem[app_idx] <= app_entry;
            dyn_mem[app_idx]   <= '{count: 8'd0, expired: 1'b0};
        end
        else if (dyn_we)
        begin
            dyn_mem[dyn_idx] <= dyn_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_entry <= entry_mem[rd_idx];
        rd_dyn   <= dyn_mem[rd_idx];
    end

endmodule

// ===== rtl/core/tre_eval.sv =====
// ----------------------------------------------------------------------------
// tre_eval
// Shared evaluation unit: applies one trigger entry to the latches and status
// for a sample, or advances its one-shot timer for a tick.
// ----------------------------------------------------------------------------
module tre_eval
    import tre_pkg::*;
(
    input  logic       is_tick,
    input  tre_entry_t entry,
    input  tre_dyn_t   dyn_i,
    input  tre_snap_t  snap,
    input  tre_io_t    io_i,
    output tre_dyn_t   dyn_o,
    output tre_io_t    io_o
);

    function automatic tre_io_t drive(input tre_io_t cur, input tre_entry_t e, input logic on);
        tre_io_t res;
        if (on)
        begin
            res.latch_b = cur.latch_b | e.out_b;
            res.latch_d = cur.latch_d | e.out_d;
            res.status  = cur.status  | e.out_s;
        end
        else
        begin
            res.latch_b = cur.latch_b & ~e.out_b;
            res.latch_d = cur.latch_d & ~e.out_d;
            res.status  = cur.status  & ~e.out_s;
        end
        return res;
    endfunction

    logic       set_lvl;
    logic [7:0] changed;
    logic [7:0] level;
    logic       level_hi;

    always_comb
    begin
        set_lvl  = entry.flags[FLAG_SET];
        changed  = (snap.chb & entry.in_b) | (snap.chd & entry.in_d) | (snap.chs & entry.in_s);
        level    = (snap.cb & entry.in_b) | (snap.cd & entry.in_d) | (snap.cs & entry.in_s);
        level_hi = (level != 8'd0);
        io_o     = io_i;
        dyn_o    = dyn_i;
        if (is_tick)
        begin
            if (dyn_i.count != 8'd0)
            begin
                dyn_o.count = dyn_i.count - 8'd1;
                if (dyn_i.count == 8'd1)
                begin
                    dyn_o.expired = 1'b1;
                end
            end
        end
        else
        begin
            // undo an expired one-shot before the rule is applied
            if (dyn_i.expired)
            begin
                io_o          = drive(io_o, entry, !set_lvl);
                dyn_o.expired = 1'b0;
            end
            if (entry.flags[FLAG_EDGE])
            begin
                if ((changed != 8'd0) && (entry.flags[FLAG_RISE] == level_hi))
                begin
                    io_o        = drive(io_o, entry, set_lvl);
                    dyn_o.count = entry.reload;
                    if (entry.flags[FLAG_CLEAR])
                    begin
                        io_o.status = io_o.status & ~entry.in_s;
                    end
                end
            end
            else
            begin
                io_o = drive(io_o, entry, set_lvl == level_hi);
            end
        end
    end

endmodule

// ===== rtl/core/io_trigger_rule_engine.sv =====
// Sequencing: a sample or tick walks the N appended triggers in ST_RUN, one table
//   entry per cycle, then ST_FIN loads the result register; append and clear go
//   straight to ST_FIN. One transaction at a time; a stalled result holds the
//   sequencer back.
// Reset (rst_n, asynchronous, active low) empties the table, zeroes latches, status
//   and snapshots, and brings both port masks up as 0xFF.
// ----------------------------------------------------------------------------
// io_trigger_rule_engine
// Programmable table of IO triggers watching ports B and D and a status byte,
// in edge mode (one-shot with timer) or level mode.
// ----------------------------------------------------------------------------
module io_trigger_rule_engine
    import tre_pkg::*;
#(
    parameter int MAX_TRIGGERS = 8
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic                  cfg_idx,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    tre_in_if.sink                in_ch,
    tre_out_if.source             out_ch
);

    // Count holds 0..MAX_TRIGGERS; index addresses one entry
    localparam int CNT_W = $clog2(MAX_TRIGGERS + 1);
    localparam int IDX_W = (MAX_TRIGGERS > 1) ? $clog2(MAX_TRIGGERS) : 1;
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_TRIGGERS);

    // Sequencer codes
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_FIN  = 2'd2;

    logic [1:0]       state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] idx_reg,   idx_next;
    logic             tick_reg,  tick_next;
    logic             ok_reg,    ok_next;
    logic [7:0]       mask_b_reg;
    logic [7:0]       mask_d_reg;
    tre_io_t          io_reg,    io_next;
    tre_snap_t        snap_reg,  snap_next;

    logic             out_valid_reg, out_valid_next;
    tre_io_t          out_io_reg;
    logic             out_ok_reg;

    logic             in_fire;
    logic             load_out;
    logic             app_we;
    tre_entry_t       app_entry;
    logic [7:0]       status_in;
    logic [7:0]       cb_in;
    logic [7:0]       cd_in;

    tre_entry_t       rd_entry;
    tre_dyn_t         rd_dyn;
    tre_dyn_t         eval_dyn;
    tre_io_t          eval_io;
    logic             run_step;

    assign in_ch.ready = (state_reg == ST_IDLE);
    assign in_fire     = in_ch.valid && in_ch.ready;
    assign run_step    = (state_reg == ST_RUN);

    // Status bits from outside logic land before the snapshot
    assign status_in = (io_reg.status | in_ch.status_set) & ~in_ch.status_clear;
    assign cb_in     = in_ch.pin_b & mask_b_reg;
    assign cd_in     = in_ch.pin_d & mask_d_reg;

    // Appended entry: port bits trimmed by the current masks, status kept whole
    always_comb
    begin
        app_entry.out_b  = in_ch.new_out_b & mask_b_reg;
        app_entry.out_d  = in_ch.new_out_d & mask_d_reg;
        app_entry.out_s  = in_ch.new_out_status;
        app_entry.in_b   = in_ch.new_in_b & mask_b_reg;
        app_entry.in_d   = in_ch.new_in_d & mask_d_reg;
        app_entry.in_s   = in_ch.new_in_status;
        app_entry.flags  = in_ch.new_mode_time[3:0];
        app_entry.reload = {in_ch.new_mode_time[7:4], 4'h0};
    end

    assign app_we = in_fire && (in_ch.op == OP_APPEND) && (count_reg < CNT_MAX);

    // Address the table with the next index, so that the registered read data
    // belongs to idx_reg while the timer write-back goes to idx_reg
    tre_table #(
        .MAX_TRIGGERS (MAX_TRIGGERS),
        .IDX_W        (IDX_W)
    ) u_table (
        .clk       (clk),
        .app_we    (app_we),
        .app_idx   (count_reg[IDX_W-1:0]),
        .app_entry (app_entry),
        .dyn_we    (run_step),
        .dyn_idx   (idx_reg[IDX_W-1:0]),
        .dyn_wdata (eval_dyn),
        .rd_idx    (idx_next[IDX_W-1:0]),
        .rd_entry  (rd_entry),
        .rd_dyn    (rd_dyn)
    );

    tre_eval u_eval (
        .is_tick (tick_reg),
        .entry   (rd_entry),
        .dyn_i   (rd_dyn),
        .snap    (snap_reg),
        .io_i    (io_reg),
        .dyn_o   (eval_dyn),
        .io_o    (eval_io)
    );

    // Result register loads once the previous result has gone
    assign load_out = (state_reg == ST_FIN) && (!out_valid_reg || out_ch.ready);

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        idx_next   = idx_reg;
        tick_next  = tick_reg;
        ok_next    = ok_reg;
        io_next    = io_reg;
        snap_next  = snap_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    ok_next    = 1'b1;
                    idx_next   = '0;
                    state_next = ST_FIN;
                    case (in_ch.op)
                        OP_SAMPLE:
                        begin
                            io_next.status = status_in;
                            snap_next.cb   = cb_in;
                            snap_next.cd   = cd_in;
                            snap_next.cs   = status_in;
                            snap_next.chb  = cb_in ^ snap_reg.cb;
                            snap_next.chd  = cd_in ^ snap_reg.cd;
                            snap_next.chs  = status_in ^ snap_reg.cs;
                            tick_next      = 1'b0;
                            if (count_reg != '0)
                            begin
                                state_next = ST_RUN;
                            end
                        end
                        OP_TICK:
                        begin
                            tick_next = 1'b1;
                            if (count_reg != '0)
                            begin
                                state_next = ST_RUN;
                            end
                        end
                        OP_APPEND:
                        begin
                            if (count_reg < CNT_MAX)
                            begin
                                count_next = count_reg + CNT_W'(1);
                            end
                            else
                            begin
                                ok_next = 1'b0;
                            end
                        end
                        OP_CLEAR:
                        begin
                            count_next = '0;
                        end
                        default:
                        begin
                            state_next = ST_FIN;
                        end
                    endcase
                end
            end
            ST_RUN:
            begin
                // advance through the table, one entry per cycle
                io_next  = eval_io;
                idx_next = idx_reg + CNT_W'(1);
                if (idx_next == count_reg)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (load_out)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            idx_reg       <= '0;
            tick_reg      <= 1'b0;
            ok_reg        <= 1'b1;
            mask_b_reg    <= MASK_RESET;
            mask_d_reg    <= MASK_RESET;
            io_reg        <= '0;
            snap_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            tick_reg      <= tick_next;
            ok_reg        <= ok_next;
            io_reg        <= io_next;
            snap_reg      <= snap_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                case (cfg_idx)
                    CFG_PORT_B_MASK: mask_b_reg <= cfg_data;
                    CFG_PORT_D_MASK: mask_d_reg <= cfg_data;
                    default:         mask_b_reg <= mask_b_reg;
                endcase
            end
        end
    end

    // Result payload, held while the transaction waits
    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_io_reg <= io_reg;
            out_ok_reg <= ok_reg;
        end
    end

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.port_b_drive = out_io_reg.latch_b;
    assign out_ch.port_d_drive = out_io_reg.latch_d;
    assign out_ch.status_now   = out_io_reg.status;
    assign out_ch.accepted     = out_ok_reg;

endmodule
